// File: rtl/bfsp_pkg.sv
// Package for the shortest-path core: opcodes, distance constants, widths.
// No dependencies.
package bfsp_pkg;
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [31:0] DIST_INF = 32'hFFFF_FFFF;
    localparam logic [31:0] DIST_MAX = 32'hFFFF_FFFE;
    localparam int NODE_W = 6;
    localparam int LEN_W  = 24;
    localparam int DIST_W = 32;
    localparam int CNT_W  = 32;
    localparam int NUM_W  = 7;
endpackage

// File: rtl/bfsp_if.sv
// Channel interfaces for the shortest-path core.
// Depends on bfsp_pkg.
interface bfsp_in_if;
    logic                    valid;
    logic                    ready;
    logic [1:0]              opcode;
    logic [5:0]              edge_source;
    logic [5:0]              edge_target;
    logic [23:0]             edge_length;
    logic                    edge_blocked;
    logic [5:0]              source_node;
    logic [5:0]              dest_node;
    modport source (output valid, opcode, edge_source, edge_target, edge_length,
                    edge_blocked, source_node, dest_node, input ready);
    modport sink (input valid, opcode, edge_source, edge_target, edge_length,
                  edge_blocked, source_node, dest_node, output ready);
endinterface

interface bfsp_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  path_node;
    logic        last;
    logic        found;
    logic [31:0] distance;
    logic [31:0] relaxations;
    logic        edges_dropped;
    modport source (output valid, path_node, last, found, distance, relaxations,
                    edges_dropped, input ready);
    modport sink (input valid, path_node, last, found, distance, relaxations,
                  edges_dropped, output ready);
endinterface

interface bfsp_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// File: rtl/bellman_ford_shortest_path_core.sv
// Top level of the Bellman-Ford shortest-path core: edge table memory,
// node memories, pass sequencer, path output. Depends on bfsp_pkg, bfsp_if.
//
// Usage: add/clear words go in on "in" and are taken one per cycle, back
// to back. A query word starts a run and stalls the input until its last
// result word has left. The run clears the node memories, then makes up
// to n-1 passes. For each source node a pass reads and checks dist[u]; a
// reached source also reads every loaded edge (edge read, then distance
// read), plus a compare and write back for each usable edge leaving it.
// The sequencer keeps one edge in flight. Then it reads the destination,
// walks the parents (read, then check and store per path node), sets up
// output, and sends one result word per cycle while the receiver takes.
// Results leave on "out", one word per path node, source first; the last
// word carries last=1. A stalled receiver holds the output register and
// the sequencer waits; a waiting word also holds off the input.
// Reset empties the edge table, clears the dropped flag and num_nodes; the
// memories themselves are not cleared. num_nodes is to be written on "cfg"
// only while idle; the core itself does not enforce this.
module bellman_ford_shortest_path_core #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    bfsp_in_if.sink      in_ch,
    bfsp_out_if.source   out_ch,
    bfsp_cfg_if.sink     cfg
);
    import bfsp_pkg::*;

    localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EC_W = $clog2(MAX_EDGES + 1);
    localparam int NA_W = $clog2(MAX_NODES);
    localparam int NC_W = $clog2(MAX_NODES + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_USRC  = 4'd2;   // read dist[u]
    localparam logic [3:0] S_UCHK  = 4'd3;
    localparam logic [3:0] S_EREAD = 4'd4;   // edge memory read issued
    localparam logic [3:0] S_DREAD = 4'd5;   // dist[to] read issued
    localparam logic [3:0] S_RELAX = 4'd6;
    localparam logic [3:0] S_DDST  = 4'd7;
    localparam logic [3:0] S_DCHK  = 4'd8;
    localparam logic [3:0] S_WALK  = 4'd9;   // read parent
    localparam logic [3:0] S_WCHK  = 4'd10;
    localparam logic [3:0] S_EMIT  = 4'd11;
    localparam logic [3:0] S_WAIT  = 4'd12;
    localparam logic [3:0] S_PREP  = 4'd13;  // first path entry read issued

    // edge table: from, to, length, blocked
    logic [NODE_W+NODE_W+LEN_W:0] edge_mem [MAX_EDGES];
    logic [NODE_W+NODE_W+LEN_W:0] edge_rd;
    logic [DIST_W-1:0] dist_mem [MAX_NODES];
    logic [DIST_W-1:0] dist_rd;
    logic [NUM_W-1:0] par_mem [MAX_NODES];
    logic [NUM_W-1:0] par_rd;
    // path stack, one entry per path node
    logic [NODE_W-1:0] path_mem [MAX_NODES];
    logic [NODE_W-1:0] path_rd;

    logic [3:0]        state_reg;
    logic [EC_W-1:0]   ecount_reg;
    logic              dropped_reg;
    logic [NUM_W-1:0]  num_nodes_reg;
    logic [NC_W-1:0]   n_reg;
    logic [NODE_W-1:0] src_reg, dst_reg;
    logic [NC_W-1:0]   u_reg;
    logic [EC_W-1:0]   e_reg;
    logic [NC_W-1:0]   pass_reg;
    logic              changed_reg;
    logic [DIST_W-1:0] du_reg;
    logic [DIST_W-1:0] nd_reg;
    logic [NODE_W-1:0] to_reg;
    logic [CNT_W-1:0]  relax_reg;
    logic [DIST_W-1:0] ddst_reg;
    logic [NC_W-1:0]   len_reg;
    logic [NODE_W-1:0] w_reg;
    logic              ovalid_reg;
    logic [NODE_W-1:0] onode_reg;
    logic              olast_reg, ofound_reg;
    logic [DIST_W-1:0] odist_reg;
    logic              edge_ok;

    logic [NUM_W-1:0]  ncl;
    assign ncl = (num_nodes_reg > NUM_W'(MAX_NODES)) ? NUM_W'(MAX_NODES) : num_nodes_reg;

    logic in_fire;
    logic q_bad;
    logic emit_go;
    logic out_load;
    assign in_ch.ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign in_fire = in_ch.valid && in_ch.ready;
    assign cfg.ready = 1'b1;

    // query ids at or above the node count give a single not-found word
    assign q_bad = (NUM_W'(in_ch.source_node) >= ncl) || (NUM_W'(in_ch.dest_node) >= ncl);
    assign emit_go = !ovalid_reg || out_ch.ready;
    // output register loads a new word
    assign out_load = (in_fire && (in_ch.opcode == OP_QUERY) && q_bad) ||
                      ((state_reg == S_DCHK) && (dist_rd == DIST_INF)) ||
                      ((state_reg == S_EMIT) && emit_go);

    assign out_ch.valid = ovalid_reg;
    assign out_ch.path_node = onode_reg;
    assign out_ch.last = olast_reg;
    assign out_ch.found = ofound_reg;
    assign out_ch.distance = odist_reg;
    assign out_ch.relaxations = relax_reg;
    assign out_ch.edges_dropped = dropped_reg;

    // edge fields of the word read from the table
    logic [NODE_W-1:0] ef_from, ef_to;
    logic [LEN_W-1:0]  ef_len;
    logic              ef_blk;
    assign {ef_from, ef_to, ef_len, ef_blk} = edge_rd;
    assign edge_ok = !ef_blk && (NC_W'(ef_from) == u_reg) && (NC_W'(ef_to) < n_reg);

    logic [DIST_W:0] sum;
    assign sum = {1'b0, du_reg} + {{(DIST_W+1-LEN_W){1'b0}}, ef_len};

    // memories
    logic              ew_en;
    logic [EA_W-1:0]   e_ra;
    assign ew_en = in_fire && (in_ch.opcode == OP_ADD) && (ecount_reg < EC_W'(MAX_EDGES));
    assign e_ra = e_reg[EA_W-1:0];
    always_ff @(posedge clk)
    begin
        if (ew_en)
        begin
            edge_mem[ecount_reg[EA_W-1:0]] <= {in_ch.edge_source, in_ch.edge_target,
                                               in_ch.edge_length, in_ch.edge_blocked};
        end
        edge_rd <= edge_mem[e_ra];
    end

    logic              dw_en, pw_en;
    logic [NA_W-1:0]   d_wa, d_ra;
    logic [DIST_W-1:0] d_wd;
    logic [NUM_W-1:0]  p_wd;
    always_comb
    begin
        dw_en = 1'b0;
        pw_en = 1'b0;
        d_wa = u_reg[NA_W-1:0];
        d_wd = DIST_INF;
        p_wd = '1;
        d_ra = u_reg[NA_W-1:0];
        case (state_reg)
            S_INIT:
            begin
                dw_en = 1'b1;
                pw_en = 1'b1;
                d_wd = (u_reg[NA_W-1:0] == src_reg[NA_W-1:0]) ? '0 : DIST_INF;
            end
            S_DREAD: d_ra = ef_to[NA_W-1:0];   // edge word is on edge_rd now
            S_RELAX:
            begin
                d_wa = to_reg[NA_W-1:0];
                d_wd = nd_reg;
                p_wd = NUM_W'(u_reg);
                dw_en = nd_reg < dist_rd;
                pw_en = dw_en;
            end
            S_DDST:  d_ra = dst_reg[NA_W-1:0];
            S_WALK:  d_ra = w_reg[NA_W-1:0];
            default: ;
        endcase
    end
    always_ff @(posedge clk)
    begin
        if (dw_en)
            dist_mem[d_wa] <= d_wd;
        if (pw_en)
            par_mem[d_wa] <= p_wd;
        dist_rd <= dist_mem[d_ra];
        par_rd <= par_mem[d_ra];
    end

    // path read runs one entry ahead while words are leaving
    logic            pth_we;
    logic [NA_W-1:0] p_ra;
    assign p_ra = len_reg[NA_W-1:0] - ((state_reg == S_EMIT && emit_go) ? NA_W'(2) : NA_W'(1));
    always_ff @(posedge clk)
    begin
        if (pth_we)
            path_mem[len_reg[NA_W-1:0]] <= w_reg;
        path_rd <= path_mem[p_ra];
    end
    assign pth_we = (state_reg == S_WCHK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ecount_reg <= '0;
            dropped_reg <= 1'b0;
            num_nodes_reg <= '0;
            ovalid_reg <= 1'b0;
            relax_reg <= '0;
            n_reg <= '0; src_reg <= '0; dst_reg <= '0; u_reg <= '0; e_reg <= '0;
            pass_reg <= '0; changed_reg <= 1'b0; du_reg <= '0; nd_reg <= '0;
            to_reg <= '0; ddst_reg <= '0; len_reg <= '0; w_reg <= '0;
            onode_reg <= '0; olast_reg <= 1'b0; ofound_reg <= 1'b0; odist_reg <= '0;
        end
        else
        begin
            if (cfg.valid)
                num_nodes_reg <= cfg.data;
            if (out_load)
                ovalid_reg <= 1'b1;
            else if (ovalid_reg && out_ch.ready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        case (in_ch.opcode)
                            OP_CLEAR:
                            begin
                                ecount_reg <= '0;
                                dropped_reg <= 1'b0;
                            end
                            OP_ADD:
                            begin
                                if (ecount_reg < EC_W'(MAX_EDGES))
                                    ecount_reg <= ecount_reg + 1'b1;
                                else
                                    dropped_reg <= 1'b1;
                            end
                            OP_QUERY:
                            begin
                                n_reg <= NC_W'(ncl);
                                src_reg <= in_ch.source_node;
                                dst_reg <= in_ch.dest_node;
                                relax_reg <= '0;
                                u_reg <= '0;
                                pass_reg <= '0;
                                if (q_bad)
                                begin
                                    // invalid ids: single not-found word
                                    onode_reg <= '0; olast_reg <= 1'b1;
                                    ofound_reg <= 1'b0; odist_reg <= '0;
                                    state_reg <= S_IDLE;
                                end
                                else
                                    state_reg <= S_INIT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_INIT:
                begin
                    if (u_reg == NC_W'(MAX_NODES - 1))
                    begin
                        u_reg <= '0;
                        changed_reg <= 1'b0;
                        state_reg <= (n_reg > NC_W'(1)) ? S_USRC : S_DDST;
                    end
                    else
                        u_reg <= u_reg + 1'b1;
                end
                S_USRC: state_reg <= S_UCHK;
                S_UCHK:
                begin
                    du_reg <= dist_rd;
                    e_reg <= '0;
                    if (dist_rd == DIST_INF || ecount_reg == '0)
                        state_reg <= S_WAIT;
                    else
                        state_reg <= S_EREAD;
                end
                S_EREAD:
                begin
                    // edge word arrives next cycle
                    state_reg <= S_DREAD;
                end
                S_DREAD:
                begin
                    to_reg <= ef_to;
                    nd_reg <= sum[DIST_W] || (sum[DIST_W-1:0] > DIST_MAX) ?
                              DIST_MAX : sum[DIST_W-1:0];
                    if (edge_ok)
                        state_reg <= S_RELAX;
                    else if (e_reg + 1'b1 == ecount_reg)
                        state_reg <= S_WAIT;
                    else
                    begin
                        e_reg <= e_reg + 1'b1;
                        state_reg <= S_EREAD;
                    end
                end
                S_RELAX:
                begin
                    if (nd_reg < dist_rd)
                    begin
                        changed_reg <= 1'b1;
                        if (relax_reg != '1)
                            relax_reg <= relax_reg + 1'b1;
                        if (NC_W'(to_reg) == u_reg)
                            du_reg <= nd_reg;
                    end
                    if (e_reg + 1'b1 == ecount_reg)
                        state_reg <= S_WAIT;
                    else
                    begin
                        e_reg <= e_reg + 1'b1;
                        state_reg <= S_EREAD;
                    end
                end
                S_WAIT:
                begin
                    // end of one source node
                    if (u_reg + 1'b1 < n_reg)
                    begin
                        u_reg <= u_reg + 1'b1;
                        state_reg <= S_USRC;
                    end
                    else if (changed_reg && (pass_reg + NC_W'(2) < n_reg))
                    begin
                        pass_reg <= pass_reg + 1'b1;
                        u_reg <= '0;
                        changed_reg <= 1'b0;
                        state_reg <= S_USRC;
                    end
                    else
                        state_reg <= S_DDST;
                end
                S_DDST: state_reg <= S_DCHK;
                S_DCHK:
                begin
                    ddst_reg <= dist_rd;
                    w_reg <= dst_reg;
                    len_reg <= '0;
                    if (dist_rd == DIST_INF)
                    begin
                        onode_reg <= '0; olast_reg <= 1'b1;
                        ofound_reg <= 1'b0; odist_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                        state_reg <= S_WALK;
                end
                S_WALK: state_reg <= S_WCHK;
                S_WCHK:
                begin
                    // w_reg stored at len_reg this cycle
                    len_reg <= len_reg + 1'b1;
                    if (w_reg == src_reg || par_rd == '1 ||
                        len_reg + 1'b1 == NC_W'(MAX_NODES))
                        state_reg <= S_PREP;
                    else
                    begin
                        w_reg <= par_rd[NODE_W-1:0];
                        state_reg <= S_WALK;
                    end
                end
                S_PREP: state_reg <= S_EMIT;
                S_EMIT:
                begin
                    // path_rd holds entry len_reg-1 (read issued last cycle)
                    if (emit_go)
                    begin
                        onode_reg <= path_rd;
                        ofound_reg <= 1'b1;
                        odist_reg <= ddst_reg;
                        olast_reg <= (len_reg == NC_W'(1));
                        len_reg <= len_reg - 1'b1;
                        state_reg <= (len_reg == NC_W'(1)) ? S_IDLE : S_EMIT;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: test/bellman_ford_shortest_path_core_tb.sv
// Testbench for bellman_ford_shortest_path_core: random and directed edge/query words,
// an in-bench shortest-path predictor, and a field-by-field check of every result word.
// Depends on bfsp_pkg, bfsp_if and the core RTL.
`timescale 1ns / 1ps

module bellman_ford_shortest_path_core_tb;
    import bfsp_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;   // ignored by the core
    localparam int TBL_DEPTH  = 256;
    localparam int NODE_LIMIT = 64;
    localparam int NO_PARENT  = 127;
    localparam int STALL_LIMIT = 400000;        // cycles with no handshake at all
    localparam int HOLD_CYCLES = 400;           // long receiver hold-off

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  src;
        logic [5:0]  dst;
        logic [23:0] len;
        logic        blocked;
        logic [5:0]  q_src;
        logic [5:0]  q_dst;
    } edge_word_t;

    typedef struct packed {
        logic [5:0]  node;
        logic        last;
        logic        found;
        logic [31:0] distance;
        logic [31:0] relax;
        logic        dropped;
    } route_word_t;

    logic clk;
    logic rst_n;

    bfsp_in_if  in_ch();
    bfsp_out_if out_ch();
    bfsp_cfg_if cfg();

    bellman_ford_shortest_path_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    // pending stimulus words and expected result words
    edge_word_t  word_q[$];
    route_word_t route_exp_q[$];

    // predictor state: edge table, dropped flag, node count
    logic [5:0]  tbl_from [TBL_DEPTH];
    logic [5:0]  tbl_to   [TBL_DEPTH];
    logic [23:0] tbl_len  [TBL_DEPTH];
    logic        tbl_blk  [TBL_DEPTH];
    int          tbl_count;
    logic        drop_flag;
    logic [6:0]  node_count;

    int  err_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_req;
    int  hold_ack;
    int  hold_left;
    int  quiet_cycles;
    bit  in_taken;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_word(input edge_word_t w);
        word_q.insert(word_q.size(), w);
    endtask

    task automatic expect_word(input route_word_t w);
        route_exp_q.insert(route_exp_q.size(), w);
    endtask

    // Shortest-path run for one query word; queues the expected result words.
    task automatic solve_route(input logic [5:0] s, input logic [5:0] d);
        int          n;
        int          pass;
        int          u;
        int          e;
        int          plen;
        int          to;
        bit          changed;
        logic [31:0] node_dist [NODE_LIMIT];
        int          par  [NODE_LIMIT];
        logic [32:0] sum;
        logic [31:0] nd;
        logic [31:0] relax;
        int          path [NODE_LIMIT];
        route_word_t w;
        n = (node_count > NODE_LIMIT) ? NODE_LIMIT : int'(node_count);
        relax = '0;
        if (s >= n || d >= n)
        begin
            w = '{node: 6'd0, last: 1'b1, found: 1'b0, distance: '0, relax: '0,
                  dropped: drop_flag};
            expect_word(w);
            return;
        end
        for (u = 0; u < NODE_LIMIT; u++)
        begin
            node_dist[u] = DIST_INF;
            par[u]  = NO_PARENT;
        end
        node_dist[s] = '0;
        for (pass = 0; pass + 1 < n; pass++)
        begin
            changed = 1'b0;
            for (u = 0; u < n; u++)
            begin
                if (node_dist[u] == DIST_INF)
                    continue;
                for (e = 0; e < tbl_count; e++)
                begin
                    if (tbl_from[e] != u || tbl_blk[e])
                        continue;
                    to = tbl_to[e];
                    if (to >= n)
                        continue;
                    sum = {1'b0, node_dist[u]} + {9'd0, tbl_len[e]};
                    nd  = (sum > {1'b0, DIST_MAX}) ? DIST_MAX : sum[31:0];
                    // strictly smaller only: ties keep the first parent
                    if (nd < node_dist[to])
                    begin
                        node_dist[to] = nd;
                        par[to]  = u;
                        if (relax != 32'hFFFF_FFFF)
                            relax++;
                        changed = 1'b1;
                    end
                end
            end
            if (!changed)
                break;
        end
        if (node_dist[d] == DIST_INF)
        begin
            w = '{node: 6'd0, last: 1'b1, found: 1'b0, distance: '0, relax: relax,
                  dropped: drop_flag};
            expect_word(w);
            return;
        end
        // walk parents back from the destination, bounded to the node limit
        plen = 0;
        u = d;
        while (plen < NODE_LIMIT)
        begin
            path[plen++] = u;
            if (u == s || par[u] == NO_PARENT)
                break;
            u = par[u] & 63;
        end
        for (int k = 0; k < plen; k++)
        begin
            w = '{node: 6'(path[plen - 1 - k]), last: (k + 1 == plen), found: 1'b1,
                  distance: node_dist[d], relax: relax, dropped: drop_flag};
            expect_word(w);
        end
    endtask

    // Sampling at the rising edge: input words feed the predictor, result words are checked.
    always @(posedge clk)
    begin
        edge_word_t  iw;
        route_word_t ew;
        in_taken <= rst_n && in_ch.valid && in_ch.ready;
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
                node_count <= cfg.data;
            if (in_ch.valid && in_ch.ready)
            begin
                iw = word_q.pop_front();
                case (iw.op)
                    OP_CLEAR:
                    begin
                        tbl_count = 0;
                        drop_flag = 1'b0;
                    end
                    OP_ADD:
                    begin
                        if (tbl_count >= TBL_DEPTH)
                            drop_flag = 1'b1;
                        else
                        begin
                            tbl_from[tbl_count] = iw.src;
                            tbl_to[tbl_count]   = iw.dst;
                            tbl_len[tbl_count]  = iw.len;
                            tbl_blk[tbl_count]  = iw.blocked;
                            tbl_count++;
                        end
                    end
                    OP_QUERY:
                        solve_route(iw.q_src, iw.q_dst);
                    default:
                        ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (route_exp_q.size() == 0)
                begin
                    $error("unexpected result word node=%0d", out_ch.path_node);
                    err_count++;
                end
                else
                begin
                    ew = route_exp_q.pop_front();
                    if (out_ch.path_node !== ew.node)
                    begin
                        $error("path_node exp %0d got %0d", ew.node, out_ch.path_node);
                        err_count++;
                    end
                    if (out_ch.last !== ew.last)
                    begin
                        $error("last exp %0d got %0d", ew.last, out_ch.last);
                        err_count++;
                    end
                    if (out_ch.found !== ew.found)
                    begin
                        $error("found exp %0d got %0d", ew.found, out_ch.found);
                        err_count++;
                    end
                    if (out_ch.distance !== ew.distance)
                    begin
                        $error("distance exp %0h got %0h", ew.distance, out_ch.distance);
                        err_count++;
                    end
                    if (out_ch.relaxations !== ew.relax)
                    begin
                        $error("relaxations exp %0d got %0d", ew.relax, out_ch.relaxations);
                        err_count++;
                    end
                    if (out_ch.edges_dropped !== ew.dropped)
                    begin
                        $error("edges_dropped exp %0d got %0d", ew.dropped,
                               out_ch.edges_dropped);
                        err_count++;
                    end
                end
            end
        end
    end

    // Driver: holds a word until taken, otherwise offers the next one or idles.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!(in_ch.valid && !in_taken))
                in_ch.valid <= (word_q.size() > 0) && ($urandom_range(99) >= send_idle_pct);
            if (word_q.size() > 0)
            begin
                in_ch.opcode       <= word_q[0].op;
                in_ch.edge_source  <= word_q[0].src;
                in_ch.edge_target  <= word_q[0].dst;
                in_ch.edge_length  <= word_q[0].len;
                in_ch.edge_blocked <= word_q[0].blocked;
                in_ch.source_node  <= word_q[0].q_src;
                in_ch.dest_node    <= word_q[0].q_dst;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (hold_req != hold_ack)
            begin
                out_ch.ready <= 1'b0;
                hold_left <= HOLD_CYCLES;
                hold_ack <= hold_ack + 1;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: a long stretch with no handshake on any channel ends the run.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic edge_word_t mk_add(int s, int d, int l, bit b);
        edge_word_t w;
        w = '0;
        w.op = OP_ADD;
        w.src = 6'(s);
        w.dst = 6'(d);
        w.len = 24'(l);
        w.blocked = b;
        return w;
    endfunction

    function automatic edge_word_t mk_query(int s, int d);
        edge_word_t w;
        w = '0;
        w.op = OP_QUERY;
        w.q_src = 6'(s);
        w.q_dst = 6'(d);
        return w;
    endfunction

    function automatic edge_word_t mk_op(logic [1:0] op);
        edge_word_t w;
        w = '0;
        w.op = op;
        return w;
    endfunction

    // node id: mostly in range, sometimes anywhere in the 6-bit field
    function automatic int pick_node(int n);
        if (n > 0 && $urandom_range(99) < 85)
            return $urandom_range((n > NODE_LIMIT ? NODE_LIMIT : n) - 1);
        return $urandom_range(63);
    endfunction

    function automatic int pick_len();
        case ($urandom_range(3))
            0: return $urandom_range(1000);
            1: return 24'hFFFFFF - $urandom_range(3);
            2: return $urandom_range(16);
            default: return $urandom_range(24'hFFFFFF);
        endcase
    endfunction

    // wait for every word taken and every result in, then let the core settle
    task automatic drain();
        while (word_q.size() > 0 || route_exp_q.size() > 0 || in_ch.valid)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_nodes(input logic [6:0] v);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= v;
        do
            @(posedge clk);
        while (!(cfg.valid && cfg.ready));
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // random graph sessions: clear, a few edges, a few queries, some noise
    task automatic random_sessions(input int n, input int words);
        int pushed;
        int k;
        pushed = 0;
        while (pushed < words)
        begin
            if (n > 10 || $urandom_range(7) != 0)
            begin
                send_word(mk_op(OP_CLEAR));
                pushed++;
            end
            k = $urandom_range(1, 12);
            repeat (k)
            begin
                send_word(mk_add(pick_node(n), pick_node(n), pick_len(),
                                 $urandom_range(99) < 15));
                pushed++;
            end
            if ($urandom_range(9) == 0)
                send_word(mk_op(OP_UNUSED));
            k = $urandom_range(1, 3);
            repeat (k)
            begin
                send_word(mk_query(pick_node(n), pick_node(n)));
                pushed++;
            end
        end
    endtask

    initial
    begin
        int node_sel [8];
        node_sel = '{6, 64, 3, 10, 2, 50, 8, 33};
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_CLEAR;
        in_ch.edge_source = '0;
        in_ch.edge_target = '0;
        in_ch.edge_length = '0;
        in_ch.edge_blocked = 1'b0;
        in_ch.source_node = '0;
        in_ch.dest_node = '0;
        out_ch.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        tbl_count = 0;
        drop_flag = 1'b0;
        node_count = '0;
        err_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 0;
        hold_ack = 0;
        hold_left = 0;
        quiet_cycles = 0;
        in_taken = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // no nodes in use: every query is invalid
        send_word(mk_query(0, 0));
        drain();

        // directed graph on four nodes
        write_nodes(7'd4);
        send_word(mk_op(OP_CLEAR));
        send_word(mk_add(0, 1, 10, 1'b0));
        send_word(mk_add(1, 2, 5, 1'b0));
        send_word(mk_add(0, 2, 15, 1'b0));        // tie with 0->1->2: the later 1->2 does not relax
        send_word(mk_add(2, 3, 1, 1'b1));         // blocked
        send_word(mk_add(2, 3, 24'hFFFFFF, 1'b0));
        send_word(mk_add(3, 63, 0, 1'b0));        // target out of range
        send_word(mk_add(63, 0, 0, 1'b0));        // source out of range
        send_word(mk_add(1, 0, 24'hAAAAAA, 1'b0));
        send_word(mk_query(0, 3));
        send_word(mk_query(0, 0));
        send_word(mk_query(3, 0));                // unreachable
        send_word(mk_query(4, 0));                // bad source
        send_word(mk_query(0, 63));               // bad destination
        send_word(mk_op(OP_UNUSED));
        send_word(mk_add(1, 3, 24'h555555, 1'b0));
        send_word(mk_query(0, 3));
        send_word(mk_query(63, 63));
        send_word(mk_op(OP_CLEAR));
        send_word(mk_query(0, 1));
        drain();

        // single node: trivial path
        write_nodes(7'd1);
        send_word(mk_query(0, 0));
        send_word(mk_query(1, 0));
        drain();

        // node count above the maximum is clipped
        write_nodes(7'd127);
        send_word(mk_op(OP_CLEAR));
        send_word(mk_add(0, 63, 300, 1'b0));
        send_word(mk_add(63, 5, 7, 1'b0));
        send_word(mk_query(0, 5));
        send_word(mk_query(0, 62));
        drain();

        // fill the table past full, then clear the sticky flag
        write_nodes(7'd3);
        send_word(mk_op(OP_CLEAR));
        repeat (TBL_DEPTH + 2)
            send_word(mk_add(pick_node(3), pick_node(3), pick_len(),
                             $urandom_range(1) == 0));
        send_word(mk_query(0, 2));
        send_word(mk_query(2, 1));
        send_word(mk_op(OP_CLEAR));
        send_word(mk_add(0, 1, 1, 1'b0));
        send_word(mk_query(0, 1));
        drain();

        // random sessions across node counts and idle patterns
        for (int ph = 0; ph < 8; ph++)
        begin
            write_nodes(7'(node_sel[ph]));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            random_sessions(node_sel[ph], 25);
            // receiver backs off while the sender keeps offering words
            if (ph == 0)
                hold_req++;
            drain();
        end

        repeat (50) @(posedge clk);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
